// File: hw/rtl/mpsj_pkg.sv
// Shared constants and types of the max-profit slot job selector.
package mpsj_pkg;

  // Sizing of the job list and of the slot space.
  localparam int MAX_JOBS   = 32;
  localparam int SLOT_COUNT = 256;

  // Field widths.
  localparam int SLOT_W   = 8;
  localparam int PROFIT_W = 16;
  localparam int SUM_W    = 21;

  // Slots at or above this limit are never chosen.
  localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W + 1)'(SLOT_COUNT);

  // One entry of the ordered job list.
  typedef struct packed {
    logic                valid;
    logic                dead;
    logic [SLOT_W-1:0]   slot;
    logic [PROFIT_W-1:0] profit;
  } job_t;

  // Controls broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                ins;
    logic                pop;
    logic [SLOT_W-1:0]   new_slot;
    logic [PROFIT_W-1:0] new_profit;
    logic                kill;
    logic [SLOT_W-1:0]   kill_slot;
  } cell_ctrl_t;

  // A chosen job with its running total.
  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [PROFIT_W-1:0] profit;
    logic [SUM_W-1:0]    total;
  } result_t;

endpackage

// File: hw/rtl/mpsj_cell.sv
// One cell of the sorted job chain: holds a job, inserts or shifts when told to, else holds it.
module mpsj_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mpsj_pkg::cell_ctrl_t ctrl_i,
  input  mpsj_pkg::job_t    upper_i,
  input  logic              take_prev_i,
  input  mpsj_pkg::job_t    lower_i,
  output mpsj_pkg::job_t    job_o,
  output logic              take_o
);
  import mpsj_pkg::*;

  job_t job_q, job_d;

  // The new job belongs here or above when this cell is empty or not more profitable.
  assign take_o = !job_q.valid || (job_q.profit <= ctrl_i.new_profit);
  assign job_o  = job_q;

  // Insertion shifts down from the upper neighbor; a pop shifts up from the lower one.
  always_comb begin
    job_d = job_q;
    if (ctrl_i.ins) begin
      if (take_prev_i) begin
        job_d = upper_i;
      end else if (take_o) begin
        job_d.valid  = 1'b1;
        job_d.dead   = 1'b0;
        job_d.slot   = ctrl_i.new_slot;
        job_d.profit = ctrl_i.new_profit;
      end
    end else if (ctrl_i.pop) begin
      job_d      = lower_i;
      job_d.dead = lower_i.dead | (ctrl_i.kill && (lower_i.slot == ctrl_i.kill_slot));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_q <= '0;
    end else begin
      job_q <= job_d;
    end
  end

endmodule

// File: hw/rtl/mpsj_chain.sv
// Row of job cells kept in descending profit order, head at cell zero.
module mpsj_chain (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mpsj_pkg::cell_ctrl_t ctrl_i,
  output mpsj_pkg::job_t       head_o,
  output logic                 full_o
);
  import mpsj_pkg::*;

  job_t               jobs [MAX_JOBS];
  logic [MAX_JOBS-1:0] take;

  // Each cell sees its upper neighbor for insertion and its lower one for popping.
  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
    job_t upper, lower;
    logic take_prev;

    if (i == 0) begin : g_top
      assign upper     = '0;
      assign take_prev = 1'b0;
    end else begin : g_mid
      assign upper     = jobs[i-1];
      assign take_prev = take[i-1];
    end

    if (i == MAX_JOBS - 1) begin : g_end
      assign lower = '0;
    end else begin : g_next
      assign lower = jobs[i+1];
    end

    mpsj_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl_i),
      .upper_i     (upper),
      .take_prev_i (take_prev),
      .lower_i     (lower),
      .job_o       (jobs[i]),
      .take_o      (take[i])
    );
  end

  assign head_o = jobs[0];
  assign full_o = jobs[MAX_JOBS-1].valid;

  // The list stays ordered: the head never has less profit than the cell after it.
  if (MAX_JOBS > 1) begin : g_chk
    a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (jobs[0].valid && jobs[1].valid) |-> (jobs[0].profit >= jobs[1].profit))
      else $error("job chain out of order at head");
  end

endmodule

// File: hw/rtl/max_profit_slot_job_selector.sv
// Top level of the max-profit slot job selector: sequencer, pending result, output register.
//
//   Channel | Direction | Handshake          | Fields
//   in      | input     | in_valid / stall   | slot_time, job_profit, last_job
//   out     | output    | out_valid / stall  | chosen_slot, chosen_profit, total_profit,
//           |           |                    | last_result
//
// Loading takes one job beat per cycle; each job is inserted into the cell chain unless it is full.
// After the last job the chain drains one cell per cycle while the output is not stalled;
// the input is stalled meanwhile.
// Reset empties the chain and clears the running total; no clearing pass is needed.
// A stalled output beat holds its register; the chain only advances when that register frees.
module max_profit_slot_job_selector (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mpsj_pkg::SLOT_W-1:0]   slot_time_i,
  input  logic [mpsj_pkg::PROFIT_W-1:0] job_profit_i,
  input  logic                          last_job_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mpsj_pkg::SLOT_W-1:0]   chosen_slot_o,
  output logic [mpsj_pkg::PROFIT_W-1:0] chosen_profit_o,
  output logic [mpsj_pkg::SUM_W-1:0]    total_profit_o,
  output logic                          last_result_o
);
  import mpsj_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

  state_e     state_q, state_d;
  cell_ctrl_t ctrl;
  job_t       head;
  logic       full;
  logic       in_beat, advance, head_pick;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_q, sum_d, sum_sat;
  result_t    pend_q, pend_d, out_q, out_d;
  logic       pend_valid_q, pend_valid_d;
  logic       out_valid_q, out_valid_d;
  logic       out_last_q, out_last_d;

  mpsj_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .head_o (head),
    .full_o (full)
  );

  // Handshake and chain control.
  assign in_stall_o = (state_q != ST_LOAD);
  assign in_beat    = in_valid_i && !in_stall_o;
  assign advance    = !out_valid_q || !out_stall_i;
  assign head_pick  = head.valid && !head.dead && (head.slot != '0) &&
                      ({1'b0, head.slot} < SLOT_LIMIT);

  always_comb begin
    ctrl            = '0;
    ctrl.ins        = in_beat && !full;
    ctrl.new_slot   = slot_time_i;
    ctrl.new_profit = job_profit_i;
    ctrl.pop        = (state_q == ST_DRAIN) && advance && head.valid;
    ctrl.kill       = ctrl.pop && head_pick;
    ctrl.kill_slot  = head.slot;
  end

  // Saturating running total.
  assign sum_wide = {1'b0, sum_q} + (SUM_W + 1)'(head.profit);
  assign sum_sat  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

  // Sequencer: a chosen job waits in the pending register until the next one
  // or the end of the batch shows whether it is the final result.
  always_comb begin
    state_d      = state_q;
    sum_d        = sum_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_LOAD: begin
        if (in_beat && last_job_i) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (advance) begin
          if (head.valid) begin
            if (head_pick) begin
              sum_d        = sum_sat;
              pend_d.slot  = head.slot;
              pend_d.profit = head.profit;
              pend_d.total = sum_sat;
              pend_valid_d = 1'b1;
              if (pend_valid_q) begin
                out_d       = pend_q;
                out_last_d  = 1'b0;
                out_valid_d = 1'b1;
              end
            end
          end else begin
            if (pend_valid_q) begin
              out_d       = pend_q;
              out_last_d  = 1'b1;
              out_valid_d = 1'b1;
            end
            pend_valid_d = 1'b0;
            sum_d        = '0;
            state_d      = ST_LOAD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      sum_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      sum_q        <= sum_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign chosen_slot_o   = out_q.slot;
  assign chosen_profit_o = out_q.profit;
  assign total_profit_o  = out_q.total;
  assign last_result_o   = out_last_q;

  // A result beat never carries the empty slot.
  a_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (chosen_slot_o != '0))
    else $error("result beat with slot zero");

  // The last job of a batch starts the drain.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && last_job_i) |=> (state_q == ST_DRAIN))
    else $error("last job did not start drain");

  // Nothing is left pending between batches.
  a_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> !pend_valid_q)
    else $error("pending result left in load state");

  // The total restarts before each batch is loaded.
  a_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> (sum_q == '0))
    else $error("running total not cleared");

endmodule
